// ===== rtl/core/lcpl_pkg.sv =====
// Shared types and constants for the layered column property lookup.
`timescale 1ns / 1ps

package lcpl_pkg;

    // Request field widths
    localparam int COL_W   = 10;
    localparam int LAY_W   = 4;
    localparam int ELEV_W  = 28;
    localparam int PROP_W  = 15;
    localparam int THR_W   = 27;

    // Default geometry
    localparam int DEF_COLUMNS = 1024;
    localparam int DEF_LAYERS  = 9;

    // Merge threshold after reset, in centimeters
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(100000);

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Material properties as stored; shear speed in the low bits
    typedef struct packed {
        logic [PROP_W-1:0] density;
        logic [PROP_W-1:0] pressure_speed;
        logic [PROP_W-1:0] shear_speed;
    } t_props;

endpackage

// ===== rtl/core/lcpl_in_if.sv =====
// Request channel: load or query command with its payload.
`timescale 1ns / 1ps

interface lcpl_in_if
    import lcpl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [COL_W-1:0]         column;
    logic [LAY_W-1:0]         layer;
    logic signed [ELEV_W-1:0] elevation;
    logic [PROP_W-1:0]        shear_speed_in;
    logic [PROP_W-1:0]        pressure_speed_in;
    logic [PROP_W-1:0]        density_in;

    modport source (
        output valid, command, column, layer, elevation,
               shear_speed_in, pressure_speed_in, density_in,
        input  ready
    );

    modport sink (
        input  valid, command, column, layer, elevation,
               shear_speed_in, pressure_speed_in, density_in,
        output ready
    );
endinterface

// ===== rtl/core/lcpl_out_if.sv =====
// Result channel: selected material properties and stale flag.
`timescale 1ns / 1ps

interface lcpl_out_if
    import lcpl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PROP_W-1:0] shear_speed;
    logic [PROP_W-1:0] pressure_speed;
    logic [PROP_W-1:0] density;
    logic              stale;

    modport source (
        output valid, shear_speed, pressure_speed, density, stale,
        input  ready
    );

    modport sink (
        input  valid, shear_speed, pressure_speed, density, stale,
        output ready
    );
endinterface

// ===== rtl/core/lcpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lcpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/layered_column_property_lookup_top.sv =====
// Top level of the layered column property lookup.
`timescale 1ns / 1ps

// Keeps a stack of LAYERS layers per column (top boundary elevation plus
// shear speed, compressional speed and density) in two RAMs, boundary and
// property, each COLUMNS*LAYERS deep with registered reads. A load
// request writes one layer entry; it produces no result. A query request
// scans the column's boundaries, one boundary RAM read per cycle, to
// bracket the point, then, unless the point is at or below the bottom
// boundary, walks deeper layers that lie within merge_threshold of the
// bracketing boundary, again one read per cycle, and finally reads the
// property RAM. A query holds the block until its result enters the
// output register. A query on a column beyond COLUMNS returns the
// previous result with stale set. The result sits in an output register,
// so a new request is taken while the previous result still waits. The
// stores are not cleared at reset: every layer of a column must be loaded
// before that column is queried. merge_threshold may only be written while
// no request is in flight.
module layered_column_property_lookup_top
    import lcpl_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int LAYERS  = DEF_LAYERS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lcpl_in_if.sink          i_req,
    lcpl_out_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata
);

    localparam int DEPTH  = COLUMNS * LAYERS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LYR_W  = $clog2(LAYERS);
    localparam int CNT_W  = $clog2(LAYERS + 1);
    localparam int PRW    = $bits(t_props);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LAYERS - 1);
    localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(LAYERS);
    localparam logic [LYR_W-1:0] LAST_LYR = LYR_W'(LAYERS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_PROP,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic [THR_W-1:0]         r_thr;
    logic [ADDR_W-1:0]        r_base;
    logic signed [ELEV_W-1:0] r_z;
    logic [CNT_W-1:0]         r_iss;
    logic [CNT_W-1:0]         r_chk;
    logic                     r_dv;
    logic signed [ELEV_W-1:0] r_top;
    logic signed [ELEV_W-1:0] r_prev_b;
    logic                     r_prev_ge;
    logic                     r_found;
    logic [LYR_W-1:0]         r_m;
    logic signed [ELEV_W-1:0] r_mref;
    logic signed [ELEV_W-1:0] r_ref;
    logic [LYR_W-1:0]         r_sel;
    logic                     r_stale;
    t_props                   r_last;
    logic                     r_out_valid;
    t_props                   r_out;
    logic                     r_out_stale;

    logic                     in_ready;
    logic                     req_acc;
    logic                     col_ok;
    logic                     lay_ok;
    logic [ADDR_W-1:0]        col_base;
    logic [ADDR_W-1:0]        ld_addr;
    logic                     mem_we;
    t_props                   ld_props;
    logic                     b_re;
    logic [ADDR_W-1:0]        b_raddr;
    logic [ELEV_W-1:0]        b_rdata;
    logic signed [ELEV_W-1:0] b_val;
    logic                     p_re;
    logic [ADDR_W-1:0]        p_raddr;
    logic [PRW-1:0]           p_rdata;
    logic                     ge_now;
    logic                     crossing;
    logic                     n_found;
    logic [LYR_W-1:0]         n_m;
    logic signed [ELEV_W-1:0] n_mref;
    logic signed [ELEV_W:0]   diff;
    logic [ELEV_W-1:0]        mag;
    logic                     near;
    logic                     at_last;
    logic                     out_free;

    // Request decode and RAM addressing
    assign in_ready = (r_state == S_IDLE);
    assign req_acc  = i_req.valid && in_ready;
    assign col_ok   = 32'(i_req.column) < COLUMNS;
    assign lay_ok   = 32'(i_req.layer) < LAYERS;
    assign col_base = ADDR_W'(32'(i_req.column) * 32'(LAYERS));
    assign ld_addr  = col_base + ADDR_W'(i_req.layer);
    assign mem_we   = req_acc && (i_req.command == CMD_LOAD) && col_ok && lay_ok;
    assign ld_props = '{density:        i_req.density_in,
                        pressure_speed: i_req.pressure_speed_in,
                        shear_speed:    i_req.shear_speed_in};

    assign b_re    = ((r_state == S_SCAN) || (r_state == S_WALK)) && (r_iss < NUM_CNT);
    assign b_raddr = r_base + ADDR_W'(r_iss[LYR_W-1:0]);
    assign p_re    = (r_state == S_PROP);
    assign p_raddr = r_base + ADDR_W'(r_sel);

    lcpl_ram #(
        .WIDTH (ELEV_W),
        .DEPTH (DEPTH)
    ) u_bnd_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ld_addr),
        .i_wdata (i_req.elevation),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    lcpl_ram #(
        .WIDTH (PRW),
        .DEPTH (DEPTH)
    ) u_prop_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ld_addr),
        .i_wdata (ld_props),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    // Bracket tracking on the boundary arriving this cycle
    always_comb begin
        b_val    = signed'(b_rdata);
        ge_now   = (b_val >= r_z);
        at_last  = (r_chk == LAST_CNT);
        crossing = (r_chk != '0) && r_prev_ge && !ge_now;
        n_found  = r_found || crossing;
        n_m      = crossing ? LYR_W'(r_chk - CNT_W'(1)) : r_m;
        n_mref   = crossing ? r_prev_b : r_mref;
    end

    // Merge test against the walk's reference boundary
    always_comb begin
        diff = {r_ref[ELEV_W-1], r_ref} - {b_val[ELEV_W-1], b_val};
        mag  = diff[ELEV_W] ? ELEV_W'(-diff) : diff[ELEV_W-1:0];
        near = mag < ELEV_W'(r_thr);
    end

    assign out_free = !r_out_valid || o_rsp.ready;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Lookup sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_acc && (i_req.command == CMD_QUERY)) begin
                        r_base  <= col_base;
                        r_z     <= i_req.elevation;
                        r_iss   <= '0;
                        r_chk   <= '0;
                        r_dv    <= 1'b0;
                        r_found <= 1'b0;
                        r_stale <= !col_ok;
                        r_state <= col_ok ? S_SCAN : S_OUT;
                    end
                end

                S_SCAN: begin
                    r_dv <= b_re;
                    if (b_re) begin
                        r_iss <= r_iss + CNT_W'(1);
                    end
                    if (r_dv) begin
                        r_chk     <= r_chk + CNT_W'(1);
                        r_prev_b  <= b_val;
                        r_prev_ge <= ge_now;
                        r_found   <= n_found;
                        r_m       <= n_m;
                        r_mref    <= n_mref;
                        if (r_chk == '0) begin
                            r_top <= b_val;
                        end
                        if (at_last) begin
                            r_dv <= 1'b0;
                            if (r_z <= b_val) begin
                                // at or below the bottom boundary
                                r_sel   <= LAST_LYR;
                                r_state <= S_PROP;
                            end else if (r_z > r_top) begin
                                // above the top: walk from layer 0
                                r_sel   <= '0;
                                r_ref   <= r_top;
                                r_iss   <= CNT_W'(1);
                                r_chk   <= CNT_W'(1);
                                r_state <= S_WALK;
                            end else if (n_found) begin
                                r_sel   <= n_m;
                                r_ref   <= n_mref;
                                r_iss   <= CNT_W'(n_m) + CNT_W'(1);
                                r_chk   <= CNT_W'(n_m) + CNT_W'(1);
                                r_state <= S_WALK;
                            end else begin
                                r_stale <= 1'b1;
                                r_state <= S_OUT;
                            end
                        end
                    end
                end

                S_WALK: begin
                    r_dv <= b_re;
                    if (b_re) begin
                        r_iss <= r_iss + CNT_W'(1);
                    end
                    if (r_dv) begin
                        r_chk <= r_chk + CNT_W'(1);
                        if (near) begin
                            r_sel <= r_chk[LYR_W-1:0];
                        end
                        // stop on the first distinct boundary or the last layer
                        if (!near || at_last) begin
                            r_dv    <= 1'b0;
                            r_state <= S_PROP;
                        end
                    end
                end

                S_PROP: begin
                    r_state <= S_OUT;
                end

                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_stale <= r_stale;
                        if (r_stale) begin
                            r_out <= r_last;
                        end else begin
                            r_out  <= t_props'(p_rdata);
                            r_last <= t_props'(p_rdata);
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.shear_speed    = r_out.shear_speed;
    assign o_rsp.pressure_speed = r_out.pressure_speed;
    assign o_rsp.density        = r_out.density;
    assign o_rsp.stale          = r_out_stale;

    // Boundary data only pending while a pass over the column is running
    a_dv_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN || r_state == S_WALK))
        else $error("boundary read data pending outside a scan or walk");

    // A load never overlaps a lookup read
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (!b_re && !p_re))
        else $error("store write during a lookup");

    // Selected layer stays inside the column
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROP) |-> (32'(r_sel) < LAYERS))
        else $error("selected layer out of range");

    // Leaving the result state always loads the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not registered");

    // A walk checks the layer right behind its latest selected layer
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_chk == CNT_W'(r_sel) + CNT_W'(1)))
        else $error("walk position out of step with selected layer");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the layered column property lookup.
`timescale 1ns / 1ps

module testbench;
    import lcpl_pkg::*;

    localparam int COLUMNS     = DEF_COLUMNS;
    localparam int LAYERS      = DEF_LAYERS;
    localparam int ELEV_MAX    = 100000000;
    localparam int PROP_MAX    = 20000;
    localparam int SETTLE      = 30;     // longer than the slowest query
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 130;
    localparam int PHASES      = 6;

    typedef struct {
        logic                     command;
        logic [COL_W-1:0]         column;
        logic [LAY_W-1:0]         layer;
        logic signed [ELEV_W-1:0] elevation;
        t_props                   props;
    } t_request;

    typedef struct {
        t_props props;
        logic   stale;
    } t_lookup;

    // Shadow copy of the layer stores plus the queue of predicted lookups
    class lookup_scoreboard;
        logic signed [ELEV_W-1:0] boundary    [COLUMNS*LAYERS];
        t_props                   layer_props [COLUMNS*LAYERS];
        bit [LAYERS-1:0]          written     [COLUMNS];
        t_props                   last_props;
        logic [THR_W-1:0]         threshold;
        t_lookup                  expected_q  [$];
        int                       failures;

        function new();
            last_props = '0;
            threshold  = THR_RESET;
            failures   = 0;
            foreach (written[c]) written[c] = '0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit column_loaded(int col);
            return &written[col];
        endfunction

        function bit near_boundary(logic signed [ELEV_W-1:0] a, logic signed [ELEV_W-1:0] b);
            longint delta;
            delta = longint'(a) - longint'(b);
            if (delta < 0) delta = -delta;
            return delta < longint'(threshold);
        endfunction

        // Step deeper while boundaries stay within the threshold; stops at the last layer
        function int walk_deeper(int base, int from);
            int sel;
            sel = from;
            for (int l = from; l < LAYERS; l++) begin
                if (!near_boundary(boundary[base + from], boundary[base + l])) break;
                sel = l;
            end
            return sel;
        endfunction

        // Apply a load, or predict the lookup a query produces
        function void note_request(t_request r);
            int                       base;
            int                       sel;
            bit                       hit;
            t_lookup                  res;
            logic signed [ELEV_W-1:0] z;
            z = r.elevation;
            if (r.command == CMD_LOAD) begin
                if (r.column < COLUMNS && r.layer < LAYERS) begin
                    base = int'(r.column) * LAYERS + int'(r.layer);
                    boundary[base]              = z;
                    layer_props[base]           = r.props;
                    written[r.column][r.layer]  = 1'b1;
                end
                return;
            end
            sel  = 0;
            hit  = 1'b0;
            base = 0;
            if (r.column < COLUMNS) begin
                base = int'(r.column) * LAYERS;
                // above the top boundary
                if (z > boundary[base]) begin
                    sel = walk_deeper(base, 0);
                    hit = 1'b1;
                end
                // at or below the bottom boundary wins over the top rule
                if (z <= boundary[base + LAYERS - 1]) begin
                    sel = LAYERS - 1;
                    hit = 1'b1;
                end
                // bracketing layer, deepest bracket wins
                if (z <= boundary[base] && z > boundary[base + LAYERS - 1]) begin
                    for (int m = 0; m < LAYERS - 1; m++) begin
                        if (z <= boundary[base + m] && z > boundary[base + m + 1]) begin
                            sel = walk_deeper(base, m);
                            hit = 1'b1;
                        end
                    end
                end
            end
            if (hit) last_props = layer_props[base + sel];
            res.props = last_props;
            res.stale = ~hit;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [PROP_W-1:0] want,
                                    logic [PROP_W-1:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_lookup got);
            t_lookup want;
            if (expected_q.size() == 0) begin
                failures++;
                $display("%0t: result with no query waiting, expected none, actual %0d %0d %0d %0d",
                         $time, got.props.shear_speed, got.props.pressure_speed,
                         got.props.density, got.stale);
                return;
            end
            want = expected_q.pop_front();
            compare_field("shear_speed", want.props.shear_speed, got.props.shear_speed);
            compare_field("pressure_speed", want.props.pressure_speed,
                          got.props.pressure_speed);
            compare_field("density", want.props.density, got.props.density);
            compare_field("stale", PROP_W'(want.stale), PROP_W'(got.stale));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;
    int               idle_pct;
    int               stall_cycles = 0;

    lookup_scoreboard sb = new();

    lcpl_in_if  req_if ();
    lcpl_out_if rsp_if ();

    layered_column_property_lookup_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Result side backpressure
    always @(negedge clk) begin
        rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Observe both channels at the rising edge
    always @(posedge clk) begin : observe
        t_request seen;
        t_lookup  got;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.props.shear_speed    = rsp_if.shear_speed;
                got.props.pressure_speed = rsp_if.pressure_speed;
                got.props.density        = rsp_if.density;
                got.stale                = rsp_if.stale;
                sb.check_result(got);
            end
            if (req_if.valid && req_if.ready) begin
                seen.command              = req_if.command;
                seen.column               = req_if.column;
                seen.layer                = req_if.layer;
                seen.elevation            = req_if.elevation;
                seen.props.shear_speed    = req_if.shear_speed_in;
                seen.props.pressure_speed = req_if.pressure_speed_in;
                seen.props.density        = req_if.density_in;
                sb.note_request(seen);
            end
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int random_elevation();
        return int'($urandom_range(2 * ELEV_MAX)) - ELEV_MAX;
    endfunction

    function automatic t_props random_props();
        t_props p;
        p.shear_speed    = PROP_W'($urandom_range(PROP_MAX));
        p.pressure_speed = PROP_W'($urandom_range(PROP_MAX));
        p.density        = PROP_W'($urandom_range(PROP_MAX));
        return p;
    endfunction

    function automatic int pick_column();
        if ($urandom_range(99) < 80) return $urandom_range(15);
        return $urandom_range(COLUMNS - 1);
    endfunction

    // Present one request with a random gap in front, hold until accepted
    task automatic send_request(input t_request r);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid             <= 1'b1;
        req_if.command           <= r.command;
        req_if.column            <= r.column;
        req_if.layer             <= r.layer;
        req_if.elevation         <= r.elevation;
        req_if.shear_speed_in    <= r.props.shear_speed;
        req_if.pressure_speed_in <= r.props.pressure_speed;
        req_if.density_in        <= r.props.density;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    task automatic load_layer(input int col, input int lay, input int elev, input t_props p);
        t_request r;
        r.command   = CMD_LOAD;
        r.column    = COL_W'(col);
        r.layer     = LAY_W'(lay);
        r.elevation = ELEV_W'(elev);
        r.props     = p;
        send_request(r);
    endtask

    // Query with junk in the fields a query ignores
    task automatic send_query(input int col, input int elev);
        t_request r;
        r.command   = CMD_QUERY;
        r.column    = COL_W'(col);
        r.layer     = LAY_W'($urandom_range(15));
        r.elevation = ELEV_W'(elev);
        r.props     = random_props();
        send_request(r);
    endtask

    // Elevation near a boundary, above the top, at an extreme, or anywhere
    task automatic query_at(input int col);
        int base;
        int z;
        int r;
        base = col * LAYERS;
        r    = $urandom_range(99);
        if (r < 35)
            z = int'(sb.boundary[base + $urandom_range(LAYERS - 1)]) + int'($urandom_range(2)) - 1;
        else if (r < 50)
            z = int'(sb.boundary[base]) + int'($urandom_range(1000, 1));
        else if (r < 60)
            z = $urandom_range(1) ? ELEV_MAX : -ELEV_MAX;
        else
            z = random_elevation();
        if (z > ELEV_MAX) z = ELEV_MAX;
        if (z < -ELEV_MAX) z = -ELEV_MAX;
        send_query(col, z);
    endtask

    // Load all layers of a column in random order; sorted stacks descend with clusters
    task automatic load_column(input int col, input bit sorted);
        int elev  [LAYERS];
        int order [LAYERS];
        int j;
        int tmp;
        int step;
        int r;
        elev[0] = ($urandom_range(99) < 70) ? int'($urandom_range(ELEV_MAX)) : random_elevation();
        for (int k = 1; k < LAYERS; k++) begin
            r = $urandom_range(99);
            if (!sorted) begin
                elev[k] = random_elevation();
            end else begin
                step = (r < 10) ? 0 : (r < 45) ? int'($urandom_range(300000))
                                               : int'($urandom_range(40000000));
                elev[k] = (elev[k-1] - step < -ELEV_MAX) ? -ELEV_MAX : elev[k-1] - step;
            end
        end
        for (int k = 0; k < LAYERS; k++) order[k] = k;
        for (int k = LAYERS - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < LAYERS; k++)
            load_layer(col, order[k], elev[order[k]], random_props());
    endtask

    // Stop sending, let every lookup come back, then let the block settle
    task automatic drain_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_threshold(value);
    endtask

    // Extremes, merged groups, saturation, both edge rules and ignored loads
    task automatic run_directed();
        int     elev [LAYERS] = '{ELEV_MAX, 50000000, 49950000, 0, -10000000,
                                  -10050000, -50000000, -99950000, -ELEV_MAX};
        t_props p;
        for (int k = 0; k < LAYERS; k++) begin
            if (k == 0) p = '0;
            else if (k == 1) p = '{PROP_W'(PROP_MAX), PROP_W'(PROP_MAX), PROP_W'(PROP_MAX)};
            else p = random_props();
            load_layer(0, k, elev[k], p);
        end
        send_query(0, ELEV_MAX);
        send_query(0, 50000000);
        send_query(0, 0);
        send_query(0, -99999999);
        send_query(0, -ELEV_MAX);
        // layer index beyond the stack is dropped
        load_layer(COLUMNS - 1, LAYERS, -1, '{PROP_W'(PROP_MAX), PROP_W'(PROP_MAX),
                                              PROP_W'(PROP_MAX)});
        load_layer(COLUMNS - 1, 15, -1, random_props());
        // top pulled close to layer 1: point above it walks into the group
        load_layer(0, 0, 49990000, random_props());
        send_query(0, ELEV_MAX);
        // bottom above top: bottom rule wins
        load_layer(0, LAYERS - 1, ELEV_MAX, random_props());
        send_query(0, 0);
    endtask

    task automatic run_random_phase(input int n_items);
        int done;
        int pick;
        int col;
        int nq;
        bit paused;
        done   = 0;
        paused = 1'b0;
        while (done < n_items) begin
            // sender holds off once until everything is back
            if (!paused && done >= n_items / 2) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            col  = pick_column();
            if (pick < 55) begin
                load_column(col, $urandom_range(99) < 85);
                nq = $urandom_range(4, 1);
                repeat (nq) query_at(col);
                done += LAYERS + nq;
            end else if (pick < 80) begin
                if (sb.column_loaded(col)) begin
                    query_at(col);
                    done++;
                end
            end else if (pick < 92) begin
                // single reload, may break the ordering of a stack
                load_layer(col, $urandom_range(LAYERS - 1), random_elevation(), random_props());
                done++;
            end else begin
                load_layer(col, $urandom_range(15, LAYERS), random_elevation(), random_props());
            end
        end
    endtask

    initial begin
        logic [THR_W-1:0] thr_list [PHASES];
        thr_list[0] = '0;
        thr_list[1] = THR_W'(ELEV_MAX);
        thr_list[2] = THR_W'(1000);
        thr_list[3] = THR_W'($urandom_range(500000));
        thr_list[4] = THR_W'(100000);
        thr_list[5] = THR_W'($urandom_range(ELEV_MAX));

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_wdata                = '0;
        idle_pct                 = 9;
        req_if.valid             = 1'b0;
        req_if.command           = CMD_LOAD;
        req_if.column            = '0;
        req_if.layer             = '0;
        req_if.elevation         = '0;
        req_if.shear_speed_in    = '0;
        req_if.pressure_speed_in = '0;
        req_if.density_in        = '0;
        rsp_if.ready             = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            write_threshold(thr_list[p]);
            // one phase runs with no idling on either side
            idle_pct = (p == 2) ? 0 : 9;
            run_random_phase(PHASE_ITEMS);
        end
        drain_results();

        if (sb.failures == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lcpl_pkg.sv
rtl/core/lcpl_in_if.sv
rtl/core/lcpl_out_if.sv
rtl/core/lcpl_ram.sv
rtl/core/layered_column_property_lookup_top.sv
tb/testbench.sv
